FILE: design/lob_bbo_pkg.sv
// Shared widths, codes and bit-search helpers for the order book best-price core.
// Depends on nothing; used by the core and the checker.
package lob_bbo_pkg;

    localparam int SLOT_AW  = 12;                 // order slot address bits
    localparam int PRICE_W  = 10;                 // price tick bits
    localparam int QTY_W    = 32;
    localparam int CNT_W    = 13;                 // orders per level
    localparam int COL_W    = 5;                  // bit within an occupancy row
    localparam int ROW_W    = PRICE_W - COL_W;    // occupancy row index
    localparam int ROW_BITS = 1 << COL_W;
    localparam int LVL_AW   = PRICE_W + 1;        // {side, price}
    localparam int BM_AW    = ROW_W + 1;          // {side, row}
    localparam int SLOT_W   = 2 + PRICE_W + QTY_W; // {live, side, price, qty}
    localparam int BEST_W   = PRICE_W + 1;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_DEL = 2'd1;
    localparam logic [1:0] ACT_MOD = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // index of the highest set bit (0 when none)
    function automatic logic [COL_W-1:0] hi_bit(input logic [ROW_BITS-1:0] v);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROW_BITS; i++) begin
            if (v[i]) r = COL_W'(i);
        end
        return r;
    endfunction

    // index of the lowest set bit (0 when none)
    function automatic logic [COL_W-1:0] lo_bit(input logic [ROW_BITS-1:0] v);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = COL_W'(i);
        end
        return r;
    endfunction

endpackage

FILE: design/lob_bbo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lob_bbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/limit_order_book_bbo_core.sv
// Order book core tracking best bid and best ask over direct-indexed order slots.
// Depends on lob_bbo_pkg and lob_bbo_ram.
//
// One item is taken per command (start high, busy low); its result appears on
// o_status/o_best_bid/o_best_ask for exactly one cycle with o_valid, and the
// receiver cannot stall it. After reset a clearing sweep zeroes the slot,
// level-count and occupancy memories, with busy held high. An item then goes
// through slot read, decide and done when nothing is removed or added; an add
// or delete also reads and writes back one level, a modify to a new price two,
// and each best-price search that must cross to another occupancy row adds a
// row read. Busy drops in the result cycle, so the next transfer can be taken
// at the edge that ends it. The steps follow from the registered read data of
// the slot memory, which is then followed by a read-modify-write
// of the level-count and occupancy memories per touched level. Emptying the
// best level finds the next one through 32-bit occupancy rows plus a per-side
// row summary held in flip-flops: search the current row first, else pick the
// nearest non-empty row and read it.
module limit_order_book_bbo_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic [lob_bbo_pkg::SLOT_AW-1:0]     i_order_id,
    input  logic                                i_is_bid,
    input  logic [lob_bbo_pkg::PRICE_W-1:0]     i_price,
    input  logic [lob_bbo_pkg::QTY_W-1:0]       i_qty,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic signed [lob_bbo_pkg::BEST_W-1:0] o_best_bid,
    output logic signed [lob_bbo_pkg::BEST_W-1:0] o_best_ask
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_LRD, S_LUPD, S_SRD, S_SFIN, S_DONE
    } t_state;

    localparam int PW = lob_bbo_pkg::PRICE_W;
    localparam int CW = lob_bbo_pkg::COL_W;
    localparam int RB = lob_bbo_pkg::ROW_BITS;
    localparam int BW = lob_bbo_pkg::BEST_W;

    t_state r_state, n_state;
    logic [lob_bbo_pkg::SLOT_AW-1:0] r_clr, n_clr;
    logic [1:0]             r_act, n_act;
    logic [lob_bbo_pkg::SLOT_AW-1:0] r_id, n_id;
    logic                   r_side_in, n_side_in;
    logic [PW-1:0]          r_px, n_px;
    logic [lob_bbo_pkg::QTY_W-1:0] r_qty, n_qty;
    logic [1:0]             r_status, n_status;
    logic                   r_rem, n_rem;        // current level step removes
    logic                   r_ins_pend, n_ins_pend;
    logic                   r_cs, n_cs;          // current side
    logic [PW-1:0]          r_cp, n_cp;          // current price
    logic                   r_ins_side, n_ins_side;
    logic [PW-1:0]          r_ins_px, n_ins_px;
    logic [lob_bbo_pkg::ROW_W-1:0] r_srow, n_srow;
    logic [RB-1:0]          r_sum_bid, n_sum_bid, r_sum_ask, n_sum_ask;
    logic signed [BW-1:0]   r_top_bid, n_top_bid, r_top_ask, n_top_ask;
    logic                   r_valid, n_valid;
    logic [1:0]             r_o_status, n_o_status;

    // memory ports
    logic                   slot_we;
    logic [lob_bbo_pkg::SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [lob_bbo_pkg::SLOT_W-1:0]  slot_wdata, slot_rdata;
    logic                   lvl_we;
    logic [lob_bbo_pkg::LVL_AW-1:0]  lvl_waddr, lvl_raddr;
    logic [lob_bbo_pkg::CNT_W-1:0]   lvl_wdata, lvl_rdata;
    logic                   bm_we;
    logic [lob_bbo_pkg::BM_AW-1:0]   bm_waddr, bm_raddr;
    logic [RB-1:0]          bm_wdata, bm_rdata;

    lob_bbo_ram #(.WIDTH(lob_bbo_pkg::SLOT_W), .DEPTH(1 << lob_bbo_pkg::SLOT_AW)) u_slot (
        .i_clk, .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );
    lob_bbo_ram #(.WIDTH(lob_bbo_pkg::CNT_W), .DEPTH(1 << lob_bbo_pkg::LVL_AW)) u_lvl (
        .i_clk, .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_raddr(lvl_raddr), .o_rdata(lvl_rdata)
    );
    lob_bbo_ram #(.WIDTH(RB), .DEPTH(1 << lob_bbo_pkg::BM_AW)) u_bm (
        .i_clk, .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );

    // slot word fields
    logic                   sl_live, sl_side;
    logic [PW-1:0]          sl_px;
    assign sl_live = slot_rdata[lob_bbo_pkg::SLOT_W-1];
    assign sl_side = slot_rdata[lob_bbo_pkg::SLOT_W-2];
    assign sl_px   = slot_rdata[lob_bbo_pkg::QTY_W +: PW];

    // level update datapath
    logic [CW-1:0]          col;
    logic [lob_bbo_pkg::ROW_W-1:0] row;
    logic [RB-1:0]          cmask, rmask, newrow, sum_cur, newsum, inrow, rows;
    logic [lob_bbo_pkg::CNT_W-1:0] newcnt;
    logic signed [BW-1:0]   top_cur, cp_s;

    always_comb begin
        col     = r_cp[CW-1:0];
        row     = r_cp[PW-1:CW];
        cmask   = RB'(1) << col;
        rmask   = RB'(1) << row;
        if (r_rem) newcnt = (lvl_rdata != '0) ? lvl_rdata - 1'b1 : '0;
        else       newcnt = lvl_rdata + 1'b1;
        newrow  = (newcnt != '0) ? (bm_rdata | cmask) : (bm_rdata & ~cmask);
        sum_cur = r_cs ? r_sum_bid : r_sum_ask;
        newsum  = (newrow != '0) ? (sum_cur | rmask) : (sum_cur & ~rmask);
        top_cur = r_cs ? r_top_bid : r_top_ask;
        cp_s    = $signed({1'b0, r_cp});
        // bids look below the emptied level, asks above it
        if (r_cs) begin
            inrow = newrow & (cmask - 1'b1);
            rows  = newsum & (rmask - 1'b1);
        end else begin
            inrow = newrow & ~((cmask << 1) - 1'b1);
            rows  = newsum & ~((rmask << 1) - 1'b1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_act      = r_act;
        n_id       = r_id;
        n_side_in  = r_side_in;
        n_px       = r_px;
        n_qty      = r_qty;
        n_status   = r_status;
        n_rem      = r_rem;
        n_ins_pend = r_ins_pend;
        n_cs       = r_cs;
        n_cp       = r_cp;
        n_ins_side = r_ins_side;
        n_ins_px   = r_ins_px;
        n_srow     = r_srow;
        n_sum_bid  = r_sum_bid;
        n_sum_ask  = r_sum_ask;
        n_top_bid  = r_top_bid;
        n_top_ask  = r_top_ask;
        n_valid    = 1'b0;
        n_o_status = r_o_status;

        slot_we    = 1'b0;
        slot_waddr = r_id;
        slot_wdata = slot_rdata;
        slot_raddr = i_order_id;
        lvl_we     = 1'b0;
        lvl_waddr  = {r_cs, r_cp};
        lvl_wdata  = newcnt;
        lvl_raddr  = {r_cs, r_cp};
        bm_we      = 1'b0;
        bm_waddr   = {r_cs, row};
        bm_wdata   = newrow;
        bm_raddr   = {r_cs, row};

        unique case (r_state)
            S_CLEAR: begin
                // sweep zeros through every memory; smaller ones wrap harmlessly
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '0;
                lvl_we     = 1'b1;
                lvl_waddr  = r_clr[lob_bbo_pkg::LVL_AW-1:0];
                lvl_wdata  = '0;
                bm_we      = 1'b1;
                bm_waddr   = r_clr[lob_bbo_pkg::BM_AW-1:0];
                bm_wdata   = '0;
                n_clr      = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_act     = i_action;
                    n_id      = i_order_id;
                    n_side_in = i_is_bid;
                    n_px      = i_price;
                    n_qty     = i_qty;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_status   = lob_bbo_pkg::ST_DONE;
                n_rem      = 1'b0;
                n_ins_pend = 1'b0;
                n_ins_side = r_side_in;
                n_ins_px   = r_px;
                unique case (r_act)
                    lob_bbo_pkg::ACT_ADD: begin
                        if (sl_live) begin
                            n_status = lob_bbo_pkg::ST_DUP;
                        end else begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, r_side_in, r_px, r_qty};
                            n_ins_pend = 1'b1;
                        end
                    end
                    lob_bbo_pkg::ACT_DEL: begin
                        if (!sl_live) begin
                            n_status = lob_bbo_pkg::ST_UNKNOWN;
                        end else begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b0, slot_rdata[lob_bbo_pkg::SLOT_W-2:0]};
                            n_rem      = 1'b1;
                        end
                    end
                    lob_bbo_pkg::ACT_MOD: begin
                        if (!sl_live) begin
                            n_status = lob_bbo_pkg::ST_UNKNOWN;
                        end else if (r_qty == '0) begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b0, slot_rdata[lob_bbo_pkg::SLOT_W-2:0]};
                            n_rem      = 1'b1;
                        end else if (sl_px != r_px) begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, sl_side, r_px, r_qty};
                            n_rem      = 1'b1;
                            n_ins_pend = 1'b1;
                            n_ins_side = sl_side;
                        end else begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, sl_side, sl_px, r_qty};
                        end
                    end
                    default: ;
                endcase
                // remove first, then insert
                if (n_rem) begin
                    n_cs    = sl_side;
                    n_cp    = sl_px;
                    n_state = S_LRD;
                end else if (n_ins_pend) begin
                    n_cs    = n_ins_side;
                    n_cp    = r_px;
                    n_state = S_LRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LRD: begin
                n_state = S_LUPD;
            end
            S_LUPD: begin
                lvl_we = 1'b1;
                bm_we  = 1'b1;
                if (r_cs) n_sum_bid = newsum;
                else      n_sum_ask = newsum;
                n_state = S_DONE;
                if (!r_rem) begin
                    if (r_cs) begin
                        if (r_top_bid < 0 || cp_s > r_top_bid) n_top_bid = cp_s;
                    end else begin
                        if (r_top_ask < 0 || cp_s < r_top_ask) n_top_ask = cp_s;
                    end
                end else begin
                    if (r_ins_pend) begin
                        n_rem   = 1'b0;
                        n_cs    = r_ins_side;
                        n_cp    = r_ins_px;
                        n_state = S_LRD;
                    end
                    if (newcnt == '0 && cp_s == top_cur) begin
                        if (inrow != '0) begin
                            if (r_cs) n_top_bid = $signed({1'b0, row, lob_bbo_pkg::hi_bit(inrow)});
                            else      n_top_ask = $signed({1'b0, row, lob_bbo_pkg::lo_bit(inrow)});
                        end else if (rows == '0) begin
                            if (r_cs) n_top_bid = '1;
                            else      n_top_ask = '1;
                        end else begin
                            // hold the pending insert until the row read returns
                            n_cs    = r_cs;
                            n_cp    = r_cp;
                            n_rem   = r_rem;
                            n_srow  = r_cs ? lob_bbo_pkg::hi_bit(rows) : lob_bbo_pkg::lo_bit(rows);
                            n_state = S_SRD;
                        end
                    end
                end
            end
            S_SRD: begin
                bm_raddr = {r_cs, r_srow};
                n_state  = S_SFIN;
            end
            S_SFIN: begin
                if (r_cs) n_top_bid = $signed({1'b0, r_srow, lob_bbo_pkg::hi_bit(bm_rdata)});
                else      n_top_ask = $signed({1'b0, r_srow, lob_bbo_pkg::lo_bit(bm_rdata)});
                if (r_ins_pend) begin
                    n_rem   = 1'b0;
                    n_cs    = r_ins_side;
                    n_cp    = r_ins_px;
                    n_state = S_LRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid    = 1'b1;
                n_o_status = r_status;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_sum_bid <= '0;
            r_sum_ask <= '0;
            r_top_bid <= '1;
            r_top_ask <= '1;
            r_valid   <= 1'b0;
            r_rem     <= 1'b0;
            r_ins_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_sum_bid <= n_sum_bid;
            r_sum_ask <= n_sum_ask;
            r_top_bid <= n_top_bid;
            r_top_ask <= n_top_ask;
            r_valid   <= n_valid;
            r_rem     <= n_rem;
            r_ins_pend <= n_ins_pend;
        end
        r_act      <= n_act;
        r_id       <= n_id;
        r_side_in  <= n_side_in;
        r_px       <= n_px;
        r_qty      <= n_qty;
        r_status   <= n_status;
        r_cs       <= n_cs;
        r_cp       <= n_cp;
        r_ins_side <= n_ins_side;
        r_ins_px   <= n_ins_px;
        r_srow     <= n_srow;
        r_o_status <= n_o_status;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_o_status;
    assign o_best_bid = r_top_bid;
    assign o_best_ask = r_top_ask;
endmodule

FILE: design/lob_bbo_checker.sv
// Port-level checks for the order book core, bound to the top level.
// Depends on lob_bbo_pkg.
module lob_bbo_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [1:0]                          o_status,
    input logic signed [lob_bbo_pkg::BEST_W-1:0] o_best_bid,
    input logic signed [lob_bbo_pkg::BEST_W-1:0] o_best_ask
);
    // an accepted command keeps the core busy until its result is out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after transfer");

    // a transfer passes through decide and done before its result, so strobes never abut
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back-to-back result strobes");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == lob_bbo_pkg::ST_DONE || o_status == lob_bbo_pkg::ST_DUP
                     || o_status == lob_bbo_pkg::ST_UNKNOWN)) else $error("bad status code");

    // a result only follows a cycle in which the core was busy
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy)) else $error("result without work");
endmodule

bind limit_order_book_bbo_core lob_bbo_checker u_lob_bbo_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the order book best-bid/best-ask core.
// Depends on lob_bbo_pkg and limit_order_book_bbo_core; no external files.
module tb_top;
    localparam int SLOT_AW = lob_bbo_pkg::SLOT_AW;
    localparam int PRICE_W = lob_bbo_pkg::PRICE_W;
    localparam int QTY_W   = lob_bbo_pkg::QTY_W;
    localparam int BEST_W  = lob_bbo_pkg::BEST_W;
    localparam int NSLOTS = 1 << SLOT_AW;
    localparam int NTICKS = 1 << PRICE_W;
    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 400000;
    // action code with no meaning: the book stays as it is
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [SLOT_AW-1:0] order_id;
        logic               is_bid;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               hold_for_drain; // wait until nothing is expected before sending
    } t_order_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [BEST_W-1:0] bid_px;
        logic [BEST_W-1:0] ask_px;
    } t_book_reply;

    logic i_clk, i_rst_n, start, busy, o_valid;
    logic [1:0] i_action, o_status;
    logic [SLOT_AW-1:0] i_order_id;
    logic i_is_bid;
    logic [PRICE_W-1:0] i_price;
    logic [QTY_W-1:0] i_qty;
    logic signed [BEST_W-1:0] o_best_bid, o_best_ask;

    limit_order_book_bbo_core dut (.*);

    // Book shadow: slot contents, per-level order counts and best prices
    bit                 shadow_live  [NSLOTS];
    bit                 shadow_side  [NSLOTS];
    logic [PRICE_W-1:0] shadow_price [NSLOTS];
    logic [QTY_W-1:0]   shadow_qty   [NSLOTS];
    int                 bid_count    [NTICKS];
    int                 ask_count    [NTICKS];
    int                 top_bid, top_ask;

    t_order_cmd  pending_cmds[$];
    t_book_reply expected_replies[$];
    int          error_count;
    longint      cycle_count;
    bit          stimulus_done;
    int          gap_left;
    // ids the generator believes are live, to bias towards hits
    int          live_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [BEST_W-1:0] got,
                                   input logic [BEST_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
                 $signed(got), $signed(want));
        error_count++;
    endtask

    function automatic void place_order(input int id, input bit side,
                                        input logic [PRICE_W-1:0] px,
                                        input logic [QTY_W-1:0] q);
        shadow_live[id] = 1'b1;
        shadow_side[id] = side;
        shadow_price[id] = px;
        shadow_qty[id] = q;
        if (side) begin
            bid_count[px]++;
            if (top_bid < 0 || int'(px) > top_bid) top_bid = int'(px);
        end else begin
            ask_count[px]++;
            if (top_ask < 0 || int'(px) < top_ask) top_ask = int'(px);
        end
    endfunction

    function automatic void remove_order(input int id);
        int px;
        px = int'(shadow_price[id]);
        shadow_live[id] = 1'b0;
        if (shadow_side[id]) begin
            if (bid_count[px] > 0) bid_count[px]--;
            if (bid_count[px] == 0 && px == top_bid) begin
                top_bid = -1;
                for (int p = px - 1; p >= 0; p--) begin
                    if (bid_count[p] != 0) begin
                        top_bid = p;
                        break;
                    end
                end
            end
        end else begin
            if (ask_count[px] > 0) ask_count[px]--;
            if (ask_count[px] == 0 && px == top_ask) begin
                top_ask = -1;
                for (int p = px + 1; p < NTICKS; p++) begin
                    if (ask_count[p] != 0) begin
                        top_ask = p;
                        break;
                    end
                end
            end
        end
    endfunction

    // Apply one accepted command to the shadow book and return the reply it should produce
    function automatic t_book_reply apply_order_cmd(input t_order_cmd c);
        t_book_reply r;
        int id;
        bit side;
        id = int'(c.order_id);
        r.status = lob_bbo_pkg::ST_DONE;
        case (c.action)
            lob_bbo_pkg::ACT_ADD: begin
                if (shadow_live[id]) r.status = lob_bbo_pkg::ST_DUP;
                else place_order(id, c.is_bid, c.price, c.qty);
            end
            lob_bbo_pkg::ACT_DEL: begin
                if (!shadow_live[id]) r.status = lob_bbo_pkg::ST_UNKNOWN;
                else remove_order(id);
            end
            lob_bbo_pkg::ACT_MOD: begin
                if (!shadow_live[id]) r.status = lob_bbo_pkg::ST_UNKNOWN;
                else if (c.qty == '0) remove_order(id);
                else if (shadow_price[id] != c.price) begin
                    side = shadow_side[id];
                    remove_order(id);
                    place_order(id, side, c.price, c.qty);
                end else shadow_qty[id] = c.qty;
            end
            default: ;
        endcase
        r.bid_px = BEST_W'(top_bid);
        r.ask_px = BEST_W'(top_ask);
        return r;
    endfunction

    function automatic t_order_cmd make_cmd(input logic [1:0] act, input int id, input int side,
                                            input int px, input logic [QTY_W-1:0] q);
        t_order_cmd c;
        c.action = act;
        c.order_id = SLOT_AW'(id);
        c.is_bid = 1'(side);
        c.price = PRICE_W'(px);
        c.qty = q;
        c.hold_for_drain = 1'b0;
        return c;
    endfunction

    // Random quantity: mostly small, sometimes extreme, sometimes fully random
    function automatic logic [QTY_W-1:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // Prices clustered in a narrow band so levels share orders and bests move often
    function automatic int rand_price();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, NTICKS - 1);
        return $urandom_range(480, 560);
    endfunction

    function automatic int rand_id();
        if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, NSLOTS - 1);
        return $urandom_range(0, 63);
    endfunction

    // Track which ids the generator thinks are live, mirroring the command effect
    function automatic void note_liveness(input t_order_cmd c);
        int idx[$];
        idx = live_ids.find_first_index(x) with (x == int'(c.order_id));
        if (c.action == lob_bbo_pkg::ACT_ADD && idx.size() == 0)
            live_ids.insert(live_ids.size(), int'(c.order_id));
        else if ((c.action == lob_bbo_pkg::ACT_DEL ||
                  (c.action == lob_bbo_pkg::ACT_MOD && c.qty == '0)) && idx.size() != 0)
            live_ids.delete(idx[0]);
    endfunction

    task automatic queue_cmd(input t_order_cmd c);
        note_liveness(c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial begin
        t_order_cmd c;
        error_count = 0;
        stimulus_done = 1'b0;
        top_bid = -1;
        top_ask = -1;
        foreach (bid_count[p]) begin
            bid_count[p] = 0;
            ask_count[p] = 0;
        end
        foreach (shadow_live[i]) shadow_live[i] = 1'b0;

        // Directed: extremes of id and price, every action and each corner case
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, 5, 1, 0, 0));          // delete unknown id
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_MOD, NSLOTS - 1, 0, 3, 9)); // modify unknown id
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 0, 1, 0, '1));         // bid at lowest tick
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, NSLOTS - 1, 0, NTICKS - 1, 0)); // qty zero
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 0, 0, 7, 1));          // duplicate id
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 1, 1, 100, 5));
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 2, 1, 100, 6));        // second order on a level
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 3, 0, 40, 7));         // new best ask, far row
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 4, 0, 900, 8));
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_MOD, 1, 0, 100, 55));       // same price, quantity only
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, 1, 0, 0, 0));          // level keeps one order
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, 2, 0, 0, 0));          // empty best bid, search down
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_MOD, 3, 1, 950, 3));        // move ask, search up
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_MOD, 4, 1, 1, 0));          // modify to zero deletes
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, 0, 0, 0, 0));          // bid side empties
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_MOD, NSLOTS - 1, 1, 2, '1)); // move to new best ask
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, 3, 0, 0, 0));
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_DEL, NSLOTS - 1, 0, 0, 0)); // ask side empties
        queue_cmd(make_cmd(ACT_UNUSED, 9, 1, 513, 17));                 // unused action code
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 2730, 1, 682, 32'haaaa_aaaa));
        queue_cmd(make_cmd(lob_bbo_pkg::ACT_ADD, 1365, 0, 341, 32'h5555_5555));

        // Random: mostly add/modify/delete traffic on live ids, with noise
        for (int n = 0; n < N_RANDOM; n++) begin
            int r;
            r = $urandom_range(0, 19);
            if (r < 8) c = make_cmd(lob_bbo_pkg::ACT_ADD, rand_id(), $urandom_range(0, 1),
                                    rand_price(), rand_qty());
            else if (r < 13) c = make_cmd(lob_bbo_pkg::ACT_DEL, rand_id(), $urandom_range(0, 1),
                                          $urandom_range(0, NTICKS - 1), $urandom);
            else if (r < 19) c = make_cmd(lob_bbo_pkg::ACT_MOD, rand_id(), $urandom_range(0, 1),
                                          rand_price(), rand_qty());
            else c = make_cmd(ACT_UNUSED, $urandom_range(0, NSLOTS - 1), $urandom_range(0, 1),
                              $urandom_range(0, NTICKS - 1), $urandom);
            if (n == N_RANDOM / 2 || $urandom_range(0, 199) == 0) c.hold_for_drain = 1'b1;
            queue_cmd(c);
        end
        stimulus_done = 1'b1;
    end

    // Reset: assert at time zero, then release
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: feed one command per transfer with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_action <= '0;
            i_order_id <= '0;
            i_is_bid <= 1'b0;
            i_price <= '0;
            i_qty <= '0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                // transfer taken at this edge: predict its reply
                expected_replies.insert(expected_replies.size(),
                                        apply_order_cmd(pending_cmds.pop_front()));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                start <= 1'b0;
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_cmds.size() > 0 &&
                             (!pending_cmds[0].hold_for_drain || expected_replies.size() == 0)) begin
                    start <= 1'b1;
                    i_action <= pending_cmds[0].action;
                    i_order_id <= pending_cmds[0].order_id;
                    i_is_bid <= pending_cmds[0].is_bid;
                    i_price <= pending_cmds[0].price;
                    i_qty <= pending_cmds[0].qty;
                end
            end
        end
    end

    // Monitor: compare every strobed reply against the oldest prediction
    always @(posedge i_clk) begin
        t_book_reply want;
        if (i_rst_n && o_valid) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected reply, status", BEST_W'(o_status), '0);
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", BEST_W'(o_status), BEST_W'(want.status));
                if (o_best_bid !== want.bid_px)
                    report_mismatch("bid price", o_best_bid, want.bid_px);
                if (o_best_ask !== want.ask_px)
                    report_mismatch("ask price", o_best_ask, want.ask_px);
            end
        end
    end

    // End of run: drain, allow for late stray replies, then judge
    initial begin
        cycle_count = 0;
        fork
            begin
                wait (stimulus_done);
                @(posedge i_clk);
                while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
                    @(posedge i_clk);
                repeat (100) @(posedge i_clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                $display("timeout after %0d cycles", cycle_count);
                error_count++;
            end
        join_any
        if (error_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule
